// File: src/iwo_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iwo_pkg: shared types and constants of the wavetable oscillator
// Field widths, register indexes, controller states and the command and
// status groups between controller and datapath.
// ----------------------------------------------------------------------------
package iwo_pkg;

  localparam int unsigned PHASE_W     = 32;
  localparam int unsigned VOLUME_W    = 17;
  localparam int unsigned WAVE_SEL_W  = 3;
  localparam int unsigned WAVE_NUM_W  = 3;
  localparam int unsigned ENTRY_IDX_W = 10;
  localparam int unsigned ENTRY_VAL_W = 16;
  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 32;

  // Q16 gain: 1.0 and the 0.7 reset value
  localparam logic [VOLUME_W-1:0] VOLUME_ONE   = 17'd65536;
  localparam logic [VOLUME_W-1:0] VOLUME_RESET = 17'd45875;

  typedef enum logic {
    OP_GEN   = 1'b0,
    OP_WRITE = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PHASE_INC = 2'd0,
    CFG_VOLUME    = 2'd1,
    CFG_WAVE_SEL  = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_RD_B  = 3'd1,
    ST_PROD  = 3'd2,
    ST_SUM   = 3'd3,
    ST_SCALE = 3'd4,
    ST_OUT   = 3'd5
  } state_e;

  typedef struct packed {
    logic mem_we;    // write beat accepted
    logic rd_a;      // generate beat accepted, read left entry
    logic rd_b;      // read right entry, capture left
    logic prod;      // frac * (b - a)
    logic sum;       // a * 2^F + product
    logic scale;     // times volume
    logic out_load;  // round, saturate, load output, step phase
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

// File: src/iwo_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iwo_if: stream channels of the wavetable oscillator
// Input channel carries write or generate beats, output channel samples.
// ----------------------------------------------------------------------------
interface iwo_in_if
  import iwo_pkg::*;
();
  logic                          valid;
  logic                          ready;
  logic                          op;
  logic [WAVE_NUM_W-1:0]         wave_number;
  logic [ENTRY_IDX_W-1:0]        entry_index;
  logic signed [ENTRY_VAL_W-1:0] entry_value;

  modport source (output valid, op, wave_number, entry_index, entry_value, input ready);
  modport sink   (input valid, op, wave_number, entry_index, entry_value, output ready);
endinterface

interface iwo_out_if
  import iwo_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, sample, input ready);
  modport sink   (input valid, sample, output ready);
endinterface
`default_nettype wire

// File: src/iwo_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iwo_ctrl: oscillator sequencer
// Accepts beats in idle, then steps a generate beat through the two memory
// reads, interpolation, volume scaling and output load.
// ----------------------------------------------------------------------------
module iwo_ctrl
  import iwo_pkg::*;
(
  input  wire     clk_i,
  input  wire     rst_ni,
  input  wire     in_valid_i,
  input  wire     in_op_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;
  logic   accept;

  assign accept = in_valid_i && (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (in_op_i == OP_GEN)) state_d = ST_RD_B;
      end
      ST_RD_B:  state_d = ST_PROD;
      ST_PROD:  state_d = ST_SUM;
      ST_SUM:   state_d = ST_SCALE;
      ST_SCALE: state_d = ST_OUT;
      ST_OUT: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.mem_we  = accept && (in_op_i == OP_WRITE);
        cmd_o.rd_a    = accept && (in_op_i == OP_GEN);
      end
      ST_RD_B:  cmd_o.rd_b  = 1'b1;
      ST_PROD:  cmd_o.prod  = 1'b1;
      ST_SUM:   cmd_o.sum   = 1'b1;
      ST_SCALE: cmd_o.scale = 1'b1;
      ST_OUT:   cmd_o.out_load = status_i.out_free;
      default: begin
        cmd_o      = '0;
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: src/iwo_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iwo_dp: oscillator datapath
// Configuration registers, phase accumulator, wave memory, interpolation and
// volume multipliers, rounding, saturation and the output register.
// ----------------------------------------------------------------------------
module iwo_dp
  import iwo_pkg::*;
#(
  parameter int unsigned TABLE_BITS  = 10,
  parameter int unsigned WAVE_COUNT  = 8,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_we_i,
  input  wire [CFG_IDX_W-1:0]          cfg_idx_i,
  input  wire [CFG_DATA_W-1:0]         cfg_data_i,
  input  wire [WAVE_NUM_W-1:0]         wave_number_i,
  input  wire [ENTRY_IDX_W-1:0]        entry_index_i,
  input  wire signed [ENTRY_VAL_W-1:0] entry_value_i,
  input  cmd_t                         cmd_i,
  output status_t                      status_o,
  iwo_out_if.source                    out_o
);

  localparam int unsigned F     = PHASE_W - TABLE_BITS;
  localparam int unsigned WB    = (WAVE_COUNT > 1) ? $clog2(WAVE_COUNT) : 1;
  localparam int unsigned AW    = WB + TABLE_BITS;
  localparam int unsigned DEPTH = WAVE_COUNT * (2 ** TABLE_BITS);
  localparam int unsigned VW    = SAMPLE_BITS + F + 2;  // interpolated value
  localparam int unsigned PW    = VW + VOLUME_W + 1;    // scaled value

  localparam logic signed [24:0] SMAX = 25'((1 <<< (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [24:0] SMIN = -SMAX - 25'sd1;

  // configuration
  logic [PHASE_W-1:0]    phase_inc_q;
  logic [VOLUME_W-1:0]   volume_q;
  logic [WAVE_SEL_W-1:0] wave_sel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_inc_q <= '0;
      volume_q    <= VOLUME_RESET;
      wave_sel_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PHASE_INC: phase_inc_q <= cfg_data_i[PHASE_W-1:0];
        CFG_VOLUME: begin
          if (cfg_data_i[VOLUME_W-1:0] <= VOLUME_ONE) volume_q <= cfg_data_i[VOLUME_W-1:0];
        end
        CFG_WAVE_SEL:  wave_sel_q <= cfg_data_i[WAVE_SEL_W-1:0];
        default: ;
      endcase
    end
  end

  // phase accumulator, steps once per emitted sample
  logic [PHASE_W-1:0] phase_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else if (cmd_i.out_load) begin
      phase_q <= phase_q + phase_inc_q;
    end
  end

  // write side
  logic [7:0]               wnum_ext;
  logic [15:0]              eidx_ext;
  logic signed [24:0]       eval_ext;
  logic signed [24:0]       eval_sat;
  logic                     wr_en;
  logic [AW-1:0]            wr_addr;

  assign wnum_ext = 8'(wave_number_i);
  assign eidx_ext = 16'(entry_index_i);
  assign eval_ext = 25'(entry_value_i);
  assign eval_sat = (eval_ext > SMAX) ? SMAX : ((eval_ext < SMIN) ? SMIN : eval_ext);
  assign wr_en    = cmd_i.mem_we && (32'(wave_number_i) < WAVE_COUNT);
  assign wr_addr  = {wnum_ext[WB-1:0], eidx_ext[TABLE_BITS-1:0]};

  // read side: left entry on accept, right neighbor (wrapping) next cycle
  logic [7:0]            wsel_ext;
  logic                  sel_ok;
  logic [WB-1:0]         rd_wave;
  logic [TABLE_BITS-1:0] idx_a;
  logic [TABLE_BITS-1:0] idx_b;
  logic [AW-1:0]         rd_addr;

  assign wsel_ext = 8'(wave_sel_q);
  assign sel_ok   = 32'(wave_sel_q) < WAVE_COUNT;
  assign rd_wave  = sel_ok ? wsel_ext[WB-1:0] : '0;
  assign idx_a    = phase_q[PHASE_W-1:F];
  assign idx_b    = idx_a + TABLE_BITS'(1);
  assign rd_addr  = {rd_wave, cmd_i.rd_b ? idx_b : idx_a};

  logic [SAMPLE_BITS-1:0] wave_mem_q [DEPTH];
  logic [SAMPLE_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      wave_mem_q[wr_addr] <= eval_sat[SAMPLE_BITS-1:0];
    end
    if (cmd_i.rd_a || cmd_i.rd_b) begin
      rdata_q <= wave_mem_q[rd_addr];
    end
  end

  // interpolation and scaling
  logic signed [SAMPLE_BITS-1:0] a_q;
  logic signed [SAMPLE_BITS:0]   diff;
  logic signed [F:0]             frac_s;
  logic signed [VW-1:0]          prod_d, prod_q;
  logic signed [VW-1:0]          v_d, v_q;
  logic signed [PW-1:0]          p_d, p_q;

  assign diff   = $signed({rdata_q[SAMPLE_BITS-1], rdata_q}) - $signed({a_q[SAMPLE_BITS-1], a_q});
  assign frac_s = $signed({1'b0, phase_q[F-1:0]});
  assign prod_d = VW'(diff) * VW'(frac_s);
  assign v_d    = (VW'(a_q) <<< F) + prod_q;
  assign p_d    = PW'(v_q) * PW'($signed({1'b0, volume_q}));

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_b)  a_q    <= $signed(rdata_q);
    if (cmd_i.prod)  prod_q <= prod_d;
    if (cmd_i.sum)   v_q    <= v_d;
    if (cmd_i.scale) p_q    <= p_d;
  end

  // round to nearest (ties up), floor shift, saturate
  logic signed [PW-1:0]          p_rnd;
  logic signed [PW-1:0]          q_sh;
  logic signed [SAMPLE_BITS-1:0] q_sat;
  logic signed [SAMPLE_W-1:0]    sample_d;

  assign p_rnd = p_q + (PW'(1) <<< (F + 15));
  assign q_sh  = p_rnd >>> (F + 16);
  always_comb begin
    if (q_sh > PW'(SMAX)) begin
      q_sat = SAMPLE_BITS'(SMAX);
    end else if (q_sh < PW'(SMIN)) begin
      q_sat = SAMPLE_BITS'(SMIN);
    end else begin
      q_sat = q_sh[SAMPLE_BITS-1:0];
    end
  end
  assign sample_d = sel_ok ? SAMPLE_W'(q_sat) : '0;

  // output register
  logic                       out_valid_q, out_valid_d;
  logic signed [SAMPLE_W-1:0] sample_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) sample_q <= sample_d;
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.sample      = sample_q;
  assign status_o.out_free = !out_valid_q || out_o.ready;

endmodule
`default_nettype wire

// File: src/interpolating_wavetable_oscillator.sv
`default_nettype none
// A write beat stores one wave entry and yields no sample. A generate
// beat steps through the states RD_B, PROD, SUM, SCALE and OUT before the
// next acceptance: the wave memory, which has one read port, is read
// twice (left entry, then its right neighbor, which wraps to entry 0),
// followed by the interpolation multiply, the sum, the volume multiply and
// the round/saturate output load. A finished sample sits in the output
// register, so the next beat is accepted while it waits; a second sample
// waits in the last step until the first is taken. The wave memory has no
// reset and no clearing pass; only written entries may be played.
// ----------------------------------------------------------------------------
// interpolating_wavetable_oscillator: linear-interpolating DDS oscillator
// Top level joining the sequencer and the datapath.
// ----------------------------------------------------------------------------
module interpolating_wavetable_oscillator
  import iwo_pkg::*;
#(
  parameter int unsigned TABLE_BITS  = 10,
  parameter int unsigned WAVE_COUNT  = 8,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  cfg_we_i,
  input  wire [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire [CFG_DATA_W-1:0] cfg_data_i,
  iwo_in_if.sink               in_i,
  iwo_out_if.source            out_o
);

  cmd_t    cmd;
  status_t status;

  iwo_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_op_i    (in_i.op),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  iwo_dp #(
    .TABLE_BITS  (TABLE_BITS),
    .WAVE_COUNT  (WAVE_COUNT),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .wave_number_i (in_i.wave_number),
    .entry_index_i (in_i.entry_index),
    .entry_value_i (in_i.entry_value),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_o         (out_o)
  );

endmodule
`default_nettype wire

// File: src/iwo_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iwo_checker: port-level checks of the wavetable oscillator
// Watches the input and output beats and the sequencing between them.
// ----------------------------------------------------------------------------
module iwo_checker
  import iwo_pkg::*;
(
  input wire                clk_i,
  input wire                rst_ni,
  input wire                in_valid_i,
  input wire                in_ready_i,
  input wire                in_op_i,
  input wire                out_valid_i,
  input wire                out_ready_i,
  input wire [SAMPLE_W-1:0] out_sample_i
);

  logic in_beat;
  assign in_beat = in_valid_i && in_ready_i;

  // stalled sample holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_sample_i))
    else $error("output beat dropped or changed while stalled");

  // a write beat never produces a sample
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && (in_op_i == OP_WRITE) && !out_valid_i |=> !out_valid_i)
    else $error("sample appeared after a write beat");

  // a write beat completes at once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && (in_op_i == OP_WRITE) |=> in_ready_i)
    else $error("input not ready after a write beat");

  // a generate beat occupies the block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && (in_op_i == OP_GEN) |=> !in_ready_i)
    else $error("input ready right after a generate beat");

endmodule

bind interpolating_wavetable_oscillator iwo_checker u_iwo_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .in_op_i      (in_i.op),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_sample_i (out_o.sample)
);
`default_nettype wire

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: wavetable oscillator check
// Drives write and generate beats through the input channel and writes the
// gain, step and wave registers between runs. A local predictor tracks the
// phase, the registers and the wave memory and computes each interpolated,
// scaled sample. Each sample taken from the output channel is compared with
// the oldest prediction. The sender bursts with gaps and the receiver stalls.
// ----------------------------------------------------------------------------
module testbench;
  import iwo_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FRAC_W       = 22;
  localparam int unsigned NUM_WAVES    = 8;
  localparam int unsigned TABLE_LEN    = 1024;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned RUN_COUNT    = 10;
  localparam int unsigned RANDOM_ITEMS = 1520;
  // bound for ~1550 beats plus register pauses
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  iwo_in_if  in_ch ();
  iwo_out_if out_ch ();

  interpolating_wavetable_oscillator dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  // predictor state
  logic [PHASE_W-1:0]            phase_acc  = '0;
  logic [PHASE_W-1:0]            phase_step = '0;
  logic [VOLUME_W-1:0]           gain       = VOLUME_RESET;
  logic [WAVE_SEL_W-1:0]         wave_sel   = '0;
  logic signed [ENTRY_VAL_W-1:0] wave_mem [NUM_WAVES][TABLE_LEN];
  bit                            entry_valid [NUM_WAVES][TABLE_LEN];

  logic signed [SAMPLE_W-1:0] expected_samples [$];

  int unsigned mismatch_count = 0;
  int unsigned items_sent     = 0;
  int unsigned cycle_count    = 0;
  int unsigned burst_left     = 0;
  int unsigned gap_left       = 1;
  int unsigned pat_left       = 0;
  logic [31:0] ready_pat;

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    in_ch.valid = 1'b0;
    in_ch.op = OP_GEN;
    in_ch.wave_number = '0;
    in_ch.entry_index = '0;
    in_ch.entry_value = '0;
    out_ch.ready = 1'b0;
  end

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // receiver stall pattern, reloaded at random when its count runs out
  always @(posedge clk_i) begin
    if (pat_left == 0) begin
      pat_left = 48;
      case ($urandom_range(0, 3))
        0: ready_pat = '1;
        1: ready_pat = $urandom;
        2: ready_pat = $urandom | $urandom;
        default: ready_pat = $urandom & $urandom;
      endcase
    end
    out_ch.ready <= ready_pat[0];
    ready_pat = {ready_pat[0], ready_pat[31:1]};
    pat_left--;
  end

  task automatic log_error(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%s", msg);
  endtask

  always @(posedge clk_i) begin
    logic signed [SAMPLE_W-1:0] want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_samples.size() == 0) begin
        log_error($sformatf("unexpected sample %0d", out_ch.sample));
      end else begin
        want = expected_samples.pop_front();
        if (out_ch.sample !== want)
          log_error($sformatf("sample mismatch: expected %0d, got %0d", want, out_ch.sample));
      end
    end
  end

  function automatic logic signed [SAMPLE_W-1:0] predict_sample();
    logic [ENTRY_IDX_W-1:0] ia, ib;
    longint a, b, f, g, v, p, q;
    if (wave_sel >= NUM_WAVES) return '0;
    ia = phase_acc[PHASE_W-1 -: ENTRY_IDX_W];
    ib = ia + ENTRY_IDX_W'(1);  // last entry pairs with entry 0
    f = longint'(phase_acc[FRAC_W-1:0]);
    g = longint'(gain);
    a = longint'(wave_mem[wave_sel][ia]);
    b = longint'(wave_mem[wave_sel][ib]);
    v = (a <<< FRAC_W) + f * (b - a);
    p = v * g + (64'sd1 <<< (FRAC_W + 15));
    q = p >>> (FRAC_W + 16);
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[SAMPLE_W-1:0];
  endfunction

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_PHASE_INC: phase_step = data;
      CFG_VOLUME: if (data[VOLUME_W-1:0] <= VOLUME_ONE) gain = data[VOLUME_W-1:0];
      CFG_WAVE_SEL: wave_sel = data[WAVE_SEL_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic send_item(input op_e op, input logic [WAVE_NUM_W-1:0] wn,
                           input logic [ENTRY_IDX_W-1:0] idx,
                           input logic signed [ENTRY_VAL_W-1:0] val);
    if (burst_left == 0) begin
      repeat (gap_left) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
    end
    in_ch.valid <= 1'b1;
    in_ch.op <= op;
    in_ch.wave_number <= wn;
    in_ch.entry_index <= idx;
    in_ch.entry_value <= val;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    if (op == OP_WRITE) begin
      wave_mem[wn][idx] = val;
      entry_valid[wn][idx] = 1'b1;
    end else begin
      expected_samples.push_back(predict_sample());
      phase_acc += phase_step;
    end
    items_sent++;
    burst_left--;
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      gap_left = $urandom_range(1, 8);
    end
  endtask

  // drop valid and let the block drain before a register write
  task automatic wait_idle();
    if (burst_left != 0) begin
      in_ch.valid <= 1'b0;
      burst_left = 0;
      gap_left = 1;
    end
    while (expected_samples.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic signed [ENTRY_VAL_W-1:0] rand_entry();
    case ($urandom_range(0, 7))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      default: return ENTRY_VAL_W'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic write_entry(input logic [WAVE_NUM_W-1:0] wn, input logic [ENTRY_IDX_W-1:0] idx,
                             input logic signed [ENTRY_VAL_W-1:0] val);
    send_item(OP_WRITE, wn, idx, val);
  endtask

  // fill the two entries about to be read if never written, then generate
  task automatic play_sample();
    logic [ENTRY_IDX_W-1:0] ia, ib;
    ia = phase_acc[PHASE_W-1 -: ENTRY_IDX_W];
    ib = ia + ENTRY_IDX_W'(1);
    if (!entry_valid[wave_sel][ia]) write_entry(wave_sel, ia, rand_entry());
    if (!entry_valid[wave_sel][ib]) write_entry(wave_sel, ib, rand_entry());
    send_item(OP_GEN, WAVE_NUM_W'($urandom), ENTRY_IDX_W'($urandom),
              ENTRY_VAL_W'($urandom));
  endtask

  task automatic test_reset_state();
    write_entry(3'd0, 10'd0, 16'sd20000);
    write_entry(3'd0, 10'd1, -16'sd20000);
    play_sample();
    play_sample();
  endtask

  task automatic test_interp_extremes();
    wait_idle();
    cfg_write(CFG_VOLUME, CFG_DATA_W'(VOLUME_ONE));
    cfg_write(CFG_PHASE_INC, 32'h0020_0000);  // half an entry per sample
    write_entry(3'd0, 10'd0, 16'sh7fff);
    write_entry(3'd0, 10'd1, 16'sh8000);
    write_entry(3'd0, 10'd2, 16'sh7fff);
    repeat (4) play_sample();
  endtask

  task automatic test_table_wrap();
    wait_idle();
    write_entry(3'd7, 10'd1023, 16'sh8000);
    write_entry(3'd7, 10'd0, 16'sh7fff);
    wait_idle();
    cfg_write(CFG_WAVE_SEL, 32'd7);
    // land on the last entry with half a step of fraction
    cfg_write(CFG_PHASE_INC, 32'hffe0_0000 - phase_acc);
    play_sample();
    play_sample();
  endtask

  task automatic test_volume_guard();
    wait_idle();
    cfg_write(CFG_VOLUME, 32'd65537);
    play_sample();
    wait_idle();
    cfg_write(CFG_VOLUME, 32'h0001_ffff);
    cfg_write(CFG_SPARE, $urandom);
    play_sample();
    wait_idle();
    cfg_write(CFG_VOLUME, 32'd0);
    play_sample();
  endtask

  task automatic test_random_play();
    int unsigned stop_at;
    logic [31:0] mag;
    for (int unsigned run = 0; run < RUN_COUNT; run++) begin
      wait_idle();
      case (run)
        0: cfg_write(CFG_PHASE_INC, 32'h7fff_ffff);
        1: cfg_write(CFG_PHASE_INC, 32'h8000_0000);
        2: cfg_write(CFG_PHASE_INC, 32'hffff_ffff);
        3: cfg_write(CFG_PHASE_INC, 32'h0000_0000);
        default: begin
          if ($urandom_range(0, 2) != 0) begin
            mag = $urandom_range(1, 1 << 23);
            cfg_write(CFG_PHASE_INC, $urandom_range(0, 1) ? -mag : mag);
          end else begin
            cfg_write(CFG_PHASE_INC, $urandom);
          end
        end
      endcase
      if ($urandom_range(0, 2) == 0)
        cfg_write(CFG_VOLUME, {15'($urandom_range(0, 32767)), 17'd0} |
                              32'($urandom_range(65537, 131071)));
      case (run)
        1: cfg_write(CFG_VOLUME, CFG_DATA_W'(VOLUME_ONE));
        2: cfg_write(CFG_VOLUME, 32'd0);
        default: cfg_write(CFG_VOLUME, {15'($urandom_range(0, 32767)), 17'd0} |
                                       32'($urandom_range(0, 65536)));
      endcase
      cfg_write(CFG_WAVE_SEL, {29'($urandom_range(0, 32'h1fff_ffff)),
                               3'($urandom_range(0, 7))});
      if ($urandom_range(0, 3) == 0) cfg_write(CFG_SPARE, $urandom);
      stop_at = items_sent + RANDOM_ITEMS / RUN_COUNT;
      while (items_sent < stop_at) begin
        if ($urandom_range(0, 99) < 15)
          write_entry(WAVE_NUM_W'($urandom_range(0, 7)), ENTRY_IDX_W'($urandom_range(0, 1023)),
                      rand_entry());
        else
          play_sample();
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_state();
    test_interp_extremes();
    test_table_wrap();
    test_volume_guard();
    test_random_play();
    wait_idle();
    if (expected_samples.size() != 0) log_error("samples missing at end of run");
    if (mismatch_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
